// ===== hdl/sst_pkg.sv =====
// shared types, sizes and codes of the sparse set table
package sst_pkg;

    localparam int KEY_SPACE  = 4096;
    localparam int CAPACITY   = 1024;
    localparam int DATA_WIDTH = 32;

    localparam int KEY_W   = $clog2(KEY_SPACE);
    localparam int SLOT_W  = $clog2(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY + 1);

    localparam int QUEUE_DEPTH = 2;

    // fixed widths of the beat fields
    localparam int OP_FIELD_W    = 2;
    localparam int KEY_FIELD_W   = 12;
    localparam int VALUE_FIELD_W = 32;
    localparam int STAT_FIELD_W  = 2;
    localparam int SLOT_FIELD_W  = 10;
    localparam int COUNT_FIELD_W = 11;

    localparam logic [OP_FIELD_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_FIELD_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_FIELD_W-1:0] OP_LOOKUP = 2'd2;

    localparam logic [STAT_FIELD_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_FIELD_W-1:0] ST_ABSENT  = 2'd1;
    localparam logic [STAT_FIELD_W-1:0] ST_PRESENT = 2'd2;
    localparam logic [STAT_FIELD_W-1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic [OP_FIELD_W-1:0]    operation;
        logic [KEY_FIELD_W-1:0]   key;
        logic [VALUE_FIELD_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic [STAT_FIELD_W-1:0]  status;
        logic                     found;
        logic [VALUE_FIELD_W-1:0] read_value;
        logic [SLOT_FIELD_W-1:0]  slot;
        logic [COUNT_FIELD_W-1:0] entry_count;
    } t_out;

    // command after classification, as held in the queue
    typedef struct packed {
        logic [OP_FIELD_W-1:0] op;
        logic [KEY_W-1:0]      key;
        logic [DATA_WIDTH-1:0] data;
    } t_cmd;

    typedef struct packed {
        logic avail;
        t_cmd cmd;
    } t_front_if;

    typedef struct packed {
        logic pop;
        logic clearing;
    } t_back_if;

endpackage

// ===== hdl/sst_front.sv =====
// command intake: key reduction, data cut and a short command queue
module sst_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  sst_pkg::t_in     i_cmd,
    input  sst_pkg::t_back_if i_back,
    output sst_pkg::t_front_if o_front
);
    import sst_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_cmd             r_queue [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [PTR_W:0]   r_fill, n_fill;
    logic             push;
    t_cmd             cls_cmd;

    assign busy = (r_fill == (PTR_W + 1)'(QUEUE_DEPTH)) || i_back.clearing;
    assign push = start && !busy;

    // classify: key folded into the key space, data cut to the stored width
    always_comb begin
        cls_cmd.op   = i_cmd.operation;
        cls_cmd.key  = KEY_W'(i_cmd.key % KEY_SPACE);
        cls_cmd.data = DATA_WIDTH'(i_cmd.value);
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (push) begin
            n_wr_ptr = r_wr_ptr + PTR_W'(1);
        end
        if (i_back.pop) begin
            n_rd_ptr = r_rd_ptr + PTR_W'(1);
        end
        if (push && !i_back.pop) begin
            n_fill = r_fill + (PTR_W + 1)'(1);
        end else if (!push && i_back.pop) begin
            n_fill = r_fill - (PTR_W + 1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= cls_cmd;
        end
    end

    assign o_front = t_front_if'{avail: (r_fill != '0), cmd: r_queue[r_rd_ptr]};

endmodule

// ===== hdl/sst_back.sv =====
// execution sequencer with key map, reverse map and slot data memories
module sst_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sst_pkg::t_front_if i_front,
    output sst_pkg::t_back_if  o_back,
    output logic               o_strobe,
    output sst_pkg::t_out      o_result
);
    import sst_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_MAP   = 3'd2;
    localparam logic [2:0] S_SLOT  = 3'd3;
    localparam logic [2:0] S_UNMAP = 3'd4;

    localparam logic [CNT_W-1:0] EMPTY = CNT_W'(CAPACITY);

    logic [2:0]        r_state, n_state;
    logic [KEY_W-1:0]  r_clr_idx, n_clr_idx;
    logic [CNT_W-1:0]  r_count, n_count;
    t_cmd              r_cmd, n_cmd;
    logic [SLOT_W-1:0] r_hole, n_hole;
    logic              r_strobe, n_strobe;
    t_out              r_result, n_result;

    logic [CNT_W-1:0]      mem_map  [KEY_SPACE];
    logic [KEY_W-1:0]      mem_keys [CAPACITY];
    logic [DATA_WIDTH-1:0] mem_data [CAPACITY];

    logic [CNT_W-1:0]      r_map_rd;
    logic [KEY_W-1:0]      r_key_rd;
    logic [DATA_WIDTH-1:0] r_data_rd;

    logic                  map_we, keys_we, data_we;
    logic [KEY_W-1:0]      map_wa, map_ra;
    logic [CNT_W-1:0]      map_wd;
    logic [SLOT_W-1:0]     keys_wa, keys_ra, data_wa, data_ra;
    logic [KEY_W-1:0]      keys_wd;
    logic [DATA_WIDTH-1:0] data_wd;

    logic                  found;
    logic [SLOT_W-1:0]     map_slot;
    logic [CNT_W-1:0]      last_cnt;
    logic [SLOT_W-1:0]     last;
    logic                  queue_pop;

    assign found    = (r_map_rd < EMPTY);
    assign map_slot = r_map_rd[SLOT_W-1:0];
    assign last_cnt = r_count - CNT_W'(1);
    assign last     = last_cnt[SLOT_W-1:0];

    always_comb begin
        n_state   = r_state;
        n_clr_idx = r_clr_idx;
        n_count   = r_count;
        n_cmd     = r_cmd;
        n_hole    = r_hole;
        n_strobe  = 1'b0;
        n_result  = r_result;
        queue_pop = 1'b0;

        map_we  = 1'b0;
        map_wa  = r_cmd.key;
        map_wd  = EMPTY;
        map_ra  = i_front.cmd.key;
        keys_we = 1'b0;
        keys_wa = r_count[SLOT_W-1:0];
        keys_wd = r_cmd.key;
        keys_ra = last;
        data_we = 1'b0;
        data_wa = r_count[SLOT_W-1:0];
        data_wd = r_cmd.data;
        data_ra = last;

        unique case (r_state)
            S_CLEAR: begin
                map_we    = 1'b1;
                map_wa    = r_clr_idx;
                map_wd    = EMPTY;
                n_clr_idx = r_clr_idx + KEY_W'(1);
                if (r_clr_idx == KEY_W'(KEY_SPACE - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_front.avail) begin
                    queue_pop = 1'b1;
                    n_cmd     = i_front.cmd;
                    n_state   = S_MAP;
                end
            end
            S_MAP: begin
                n_result.status      = ST_OK;
                n_result.found       = found;
                n_result.read_value  = '0;
                n_result.slot        = '0;
                n_result.entry_count = COUNT_FIELD_W'(r_count);
                n_strobe             = 1'b1;
                n_state              = S_IDLE;
                unique case (r_cmd.op)
                    OP_INSERT: begin
                        if (found) begin
                            n_result.status = ST_PRESENT;
                            n_result.slot   = SLOT_FIELD_W'(map_slot);
                        end else if (r_count >= EMPTY) begin
                            n_result.status = ST_FULL;
                        end else begin
                            map_we  = 1'b1;
                            map_wd  = r_count;
                            keys_we = 1'b1;
                            data_we = 1'b1;
                            n_count = r_count + CNT_W'(1);
                            n_result.slot        = SLOT_FIELD_W'(r_count);
                            n_result.entry_count = COUNT_FIELD_W'(n_count);
                        end
                    end
                    OP_REMOVE: begin
                        if (!found) begin
                            n_result.status = ST_ABSENT;
                        end else if (map_slot == last) begin
                            map_we  = 1'b1;
                            n_count = last_cnt;
                            n_result.entry_count = COUNT_FIELD_W'(last_cnt);
                        end else begin
                            n_hole   = map_slot;
                            n_strobe = 1'b0;
                            n_state  = S_SLOT;
                        end
                    end
                    OP_LOOKUP: begin
                        if (!found) begin
                            n_result.status = ST_ABSENT;
                        end else begin
                            data_ra  = map_slot;
                            n_hole   = map_slot;
                            n_strobe = 1'b0;
                            n_state  = S_SLOT;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_SLOT: begin
                if (r_cmd.op == OP_LOOKUP) begin
                    n_result.status      = ST_OK;
                    n_result.found       = 1'b1;
                    n_result.read_value  = VALUE_FIELD_W'(r_data_rd);
                    n_result.slot        = SLOT_FIELD_W'(r_hole);
                    n_result.entry_count = COUNT_FIELD_W'(r_count);
                    n_strobe             = 1'b1;
                    n_state              = S_IDLE;
                end else begin
                    // move last slot into the hole and repoint its key
                    keys_we = 1'b1;
                    keys_wa = r_hole;
                    keys_wd = r_key_rd;
                    data_we = 1'b1;
                    data_wa = r_hole;
                    data_wd = r_data_rd;
                    map_we  = 1'b1;
                    map_wa  = r_key_rd;
                    map_wd  = CNT_W'(r_hole);
                    n_state = S_UNMAP;
                end
            end
            S_UNMAP: begin
                map_we  = 1'b1;
                map_wa  = r_cmd.key;
                map_wd  = EMPTY;
                n_count = last_cnt;
                n_result.status      = ST_OK;
                n_result.found       = 1'b1;
                n_result.read_value  = '0;
                n_result.slot        = '0;
                n_result.entry_count = COUNT_FIELD_W'(last_cnt);
                n_strobe             = 1'b1;
                n_state              = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_idx <= '0;
            r_count   <= '0;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_idx <= n_clr_idx;
            r_count   <= n_count;
            r_strobe  <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_hole   <= n_hole;
        r_result <= n_result;
    end

    always_ff @(posedge i_clk) begin
        if (map_we) begin
            mem_map[map_wa] <= map_wd;
        end
        r_map_rd <= mem_map[map_ra];
    end

    always_ff @(posedge i_clk) begin
        if (keys_we) begin
            mem_keys[keys_wa] <= keys_wd;
        end
        r_key_rd <= mem_keys[keys_ra];
    end

    always_ff @(posedge i_clk) begin
        if (data_we) begin
            mem_data[data_wa] <= data_wd;
        end
        r_data_rd <= mem_data[data_ra];
    end

    assign o_back   = t_back_if'{pop: queue_pop, clearing: (r_state == S_CLEAR)};
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

// ===== hdl/sparse_set_table_core.sv =====
// top level of the sparse set table: intake queue plus execution sequencer
//
// A command beat is taken at a rising edge where start is high and busy is
// low. Each command gives exactly one result beat, shown on o_result for a
// single cycle with o_strobe high; the receiver cannot hold results off, so
// it must take every strobed beat. After reset the key map is swept to empty,
// one entry per cycle, so busy stays high and no command is taken until the
// whole map is empty. Commands then pass a two-entry queue into the sequencer,
// whose steps follow the dependent reads of its memories: insert, remove of
// the last slot, failed operations and the unused code pass S_IDLE and S_MAP
// only, a lookup hit adds S_SLOT, and a remove that moves the last slot into
// the hole adds S_SLOT and S_UNMAP. The result beat is registered from the
// sequencer's last state. Results come back in command order.
module sparse_set_table_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  sst_pkg::t_in  i_cmd,
    output logic          o_strobe,
    output sst_pkg::t_out o_result
);
    import sst_pkg::*;

    // queue head toward the sequencer, pop and sweep state back
    t_front_if front_if;
    t_back_if  back_if;

    // intake: fold key, cut data, buffer up to two beats
    sst_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_cmd   (i_cmd),
        .i_back  (back_if),
        .o_front (front_if)
    );

    // execution: key map lookup, append or swap-remove, result register
    sst_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_front  (front_if),
        .o_back   (back_if),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

// ===== hdl/sst_checker.sv =====
// port-level checks of the sparse set table, bound to the top level
module sst_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          busy,
    input logic          o_strobe,
    input sst_pkg::t_out o_result
);
    import sst_pkg::*;

    // key map sweep holds off commands right after reset
    a_busy_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> busy && !o_strobe)
        else $error("busy low or strobe right after reset");

    // a result strobe is never followed at once by another
    a_strobe_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result beats on adjacent cycles");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> o_result.entry_count <= COUNT_FIELD_W'(CAPACITY))
        else $error("entry count above capacity");

    a_full_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.status == ST_FULL |->
            o_result.entry_count == COUNT_FIELD_W'(CAPACITY) && !o_result.found)
        else $error("full status with room left or key present");

    a_absent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.status == ST_ABSENT |->
            !o_result.found && o_result.slot == '0 && o_result.read_value == '0)
        else $error("absent key reported with data");

endmodule

bind sparse_set_table_core sst_checker u_sst_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

// ===== bench/tb_top.sv =====
// self-checking bench for the sparse set table: directed beats, random phases, scoreboard
module tb_top;
    import sst_pkg::*;

    // code 3 is not a real operation; the block must leave the table alone
    localparam logic [OP_FIELD_W-1:0] OP_UNUSED = 2'd3;

    // generous ceiling: key map sweep plus ~1500 beats at worst-case gap and cost
    localparam int RUN_LIMIT   = 2000000;
    localparam int SETTLE_CYC  = 20;

    // holds a shadow copy of the table and the results still owed by the block
    class table_scoreboard;
        logic [CNT_W-1:0]      key_map   [KEY_SPACE];
        logic [KEY_W-1:0]      slot_keys [CAPACITY];
        logic [DATA_WIDTH-1:0] slot_data [CAPACITY];
        int unsigned           stored;
        t_out                  owed [$];
        int                    errors;

        function void clear_table();
            foreach (key_map[i]) key_map[i] = CNT_W'(CAPACITY);
            stored = 0;
            owed.delete();
            errors = 0;
        endfunction

        function int pending();
            return owed.size();
        endfunction

        // apply one accepted command beat to the shadow table and queue its result
        function void note_command(t_in c);
            t_out             r;
            logic [KEY_W-1:0] k;
            logic [KEY_W-1:0] moved;
            int unsigned      hole;
            int unsigned      last;
            r = '0;
            k = KEY_W'(c.key % KEY_SPACE);
            r.found  = key_map[k] < CAPACITY;
            r.status = ST_OK;
            case (c.operation)
                OP_INSERT: begin
                    if (r.found) begin
                        r.status = ST_PRESENT;
                        r.slot   = SLOT_FIELD_W'(key_map[k]);
                    end else if (stored >= CAPACITY) begin
                        r.status = ST_FULL;
                    end else begin
                        r.slot            = SLOT_FIELD_W'(stored);
                        key_map[k]        = CNT_W'(stored);
                        slot_keys[stored] = k;
                        slot_data[stored] = c.value[DATA_WIDTH-1:0];
                        stored++;
                    end
                end
                OP_REMOVE: begin
                    if (!r.found) begin
                        r.status = ST_ABSENT;
                    end else begin
                        hole = 32'(key_map[k]);
                        last = stored - 1;
                        // fill the hole from the last slot and repoint that key
                        if (hole != last) begin
                            moved           = KEY_W'(slot_keys[last] % KEY_SPACE);
                            slot_keys[hole] = moved;
                            slot_data[hole] = slot_data[last];
                            key_map[moved]  = CNT_W'(hole);
                        end
                        key_map[k] = CNT_W'(CAPACITY);
                        stored     = last;
                    end
                end
                OP_LOOKUP: begin
                    if (!r.found) begin
                        r.status = ST_ABSENT;
                    end else begin
                        r.slot       = SLOT_FIELD_W'(key_map[k]);
                        r.read_value = VALUE_FIELD_W'(slot_data[key_map[k]]);
                    end
                end
                default: ;
            endcase
            r.entry_count = COUNT_FIELD_W'(stored);
            owed.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            end
        endfunction

        // compare one result beat with the oldest owed result
        function void check_result(t_out got);
            t_out want;
            if (owed.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat, expected none, actual %0h", $time, got);
                return;
            end
            want = owed.pop_front();
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("found", 32'(want.found), 32'(got.found));
            compare_field("read_value", 32'(want.read_value), 32'(got.read_value));
            compare_field("slot", 32'(want.slot), 32'(got.slot));
            compare_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
        endfunction
    endclass

    logic  i_clk = 1'b0;
    logic  i_rst_n;
    logic  start;
    logic  busy;
    t_in   i_cmd;
    logic  o_strobe;
    t_out  o_result;

    table_scoreboard sb = new();

    // sender pacing: idle gaps come in stretches, with some stretches packed tight
    bit idle_on;
    int beats_sent;

    always #2 i_clk = ~i_clk;

    sparse_set_table_core DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // results cannot be held off, so every strobed beat is checked on the edge that ends it
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_strobe === 1'b1) begin
            sb.check_result(o_result);
        end
    end

    // one command beat; called on the edge that took the previous beat, so start
    // stays high across back-to-back beats and is only lowered when a gap is drawn
    task automatic send_command(logic [OP_FIELD_W-1:0] op, logic [KEY_FIELD_W-1:0] key,
                                logic [VALUE_FIELD_W-1:0] value);
        t_in c;
        int  gap;
        if (beats_sent % 50 == 0) begin
            idle_on = $urandom_range(0, 2) != 0;
        end
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        c.operation = op;
        c.key       = key;
        c.value     = value;
        start <= 1'b1;
        i_cmd <= c;
        // busy read here is the value the edge saw
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_command(c);
        beats_sent++;
    endtask

    // hold off the sender until every owed result has come back
    task automatic drain_results();
        start <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
    endtask

    function automatic logic [OP_FIELD_W-1:0] pick_op(int ins, int rem, int look);
        int r;
        r = $urandom_range(0, 99);
        if (r < ins) return OP_INSERT;
        if (r < ins + rem) return OP_REMOVE;
        if (r < ins + rem + look) return OP_LOOKUP;
        return OP_UNUSED;
    endfunction

    // a stored key with chance stored_pct, else any key, so removes and lookups can hit
    function automatic logic [KEY_FIELD_W-1:0] pick_key(int stored_pct);
        if (sb.stored > 0 && $urandom_range(0, 99) < stored_pct) begin
            return KEY_FIELD_W'(sb.slot_keys[$urandom_range(0, sb.stored - 1)]);
        end
        return KEY_FIELD_W'($urandom_range(0, KEY_SPACE - 1));
    endfunction

    initial begin
        logic [OP_FIELD_W-1:0]  op;
        logic [KEY_FIELD_W-1:0] key;
        sb.clear_table();
        beats_sent = 0;
        idle_on    = 1'b0;
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_cmd   <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, field extremes, present insert, unused code,
        // remove with a move, remove of the last slot, table emptied again
        send_command(OP_LOOKUP, 12'h000, 32'h0000_0000);
        send_command(OP_REMOVE, 12'hFFF, 32'hFFFF_FFFF);
        send_command(OP_INSERT, 12'h000, 32'h0000_0000);
        send_command(OP_INSERT, 12'hFFF, 32'hFFFF_FFFF);
        send_command(OP_INSERT, 12'h000, 32'h1234_5678);
        send_command(OP_LOOKUP, 12'hFFF, 32'h0000_0000);
        send_command(OP_LOOKUP, 12'h000, 32'hFFFF_FFFF);
        send_command(OP_UNUSED, 12'hFFF, 32'hFFFF_FFFF);
        send_command(OP_UNUSED, 12'h4D2, 32'h0000_0000);
        send_command(OP_INSERT, 12'hAAA, 32'hA5A5_A5A5);
        send_command(OP_INSERT, 12'h555, 32'h5A5A_5A5A);
        send_command(OP_REMOVE, 12'h000, 32'h0000_0000);
        send_command(OP_LOOKUP, 12'h555, 32'h0000_0000);
        send_command(OP_REMOVE, 12'hAAA, 32'h0000_0000);
        send_command(OP_LOOKUP, 12'hAAA, 32'h0000_0000);
        send_command(OP_REMOVE, 12'hFFF, 32'h0000_0000);
        send_command(OP_REMOVE, 12'h555, 32'h0000_0000);
        send_command(OP_LOOKUP, 12'h555, 32'h0000_0000);
        send_command(OP_REMOVE, 12'h000, 32'h0000_0000);
        send_command(OP_INSERT, 12'h800, 32'h8000_0000);
        drain_results();

        // small key pool: lots of hits, repeated moves of the last slot
        repeat (150) begin
            op  = pick_op(40, 30, 25);
            key = KEY_FIELD_W'($urandom_range(0, 31));
            if (key >= 16) key = key + 12'hFD0;
            send_command(op, key, $urandom());
        end

        // fill the table to capacity with random keys; present-key inserts show up late
        while (sb.stored < CAPACITY) begin
            op = pick_op(92, 3, 4);
            send_command(op, pick_key(op == OP_INSERT ? 0 : 50), $urandom());
        end

        // table at capacity: inserts hit full or present, removes reopen room briefly
        repeat (150) begin
            op = pick_op(40, 30, 25);
            send_command(op, pick_key(op == OP_INSERT ? 20 : 60), $urandom());
        end

        drain_results();
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // stuck handshake or lost result
    initial begin
        #RUN_LIMIT;
        $display("status: fail");
        $finish;
    end

endmodule

// ===== sparse_set_table_core.f =====
hdl/sst_pkg.sv
hdl/sst_front.sv
hdl/sst_back.sv
hdl/sparse_set_table_core.sv
hdl/sst_checker.sv
bench/tb_top.sv
